FILE: src/sphere_clearance_min_core_assert.svh
// Assertion macros for the sphere clearance core
`ifndef SPHERE_CLEARANCE_MIN_CORE_ASSERT_SVH
`define SPHERE_CLEARANCE_MIN_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SCM_ASSERT_IMP(label, clk, rst, a, c, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
`define SCM_ASSERT_NEXT(label, clk, rst, a, c, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`else
`define SCM_ASSERT_IMP(label, clk, rst, a, c, msg)
`define SCM_ASSERT_NEXT(label, clk, rst, a, c, msg)
`endif
`endif

FILE: src/scm_pkg.sv
// Shared types and constants for the sphere clearance core
`default_nettype none
package scm_pkg;
   localparam int NUM_OBSTACLES = 16;
   localparam int NUM_POINTS = 8;
   localparam int SLOT_W = (NUM_OBSTACLES > 1) ? $clog2(NUM_OBSTACLES) : 1;
   localparam int CNT_W = $clog2(NUM_OBSTACLES + 64);
   localparam int SQ_W = 50;
   localparam int ROOT_W = 25;
   localparam int STEP_W = 5;
   localparam logic signed [23:0] CODE_MAX = 24'sh7FFFFF;
   localparam logic signed [23:0] CODE_MIN = -24'sh800000;
   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   typedef struct packed {
      logic req_type;
      logic [3:0] entry_index;
      logic signed [23:0] pos_x;
      logic signed [23:0] pos_y;
      logic signed [23:0] pos_z;
      logic [16:0] radius;
   } req_type_type;

   typedef struct packed {
      logic signed [23:0] point_clearance;
      logic signed [23:0] pose_clearance;
   } rsp_type;

   typedef struct packed {
      logic signed [23:0] cx;
      logic signed [23:0] cy;
      logic signed [23:0] cz;
      logic [16:0] rad;
   } sphere_type;

   typedef struct packed {
      logic valid;
      logic [SQ_W-1:0] rem;
      logic [ROOT_W:0] root;
      logic [SQ_W-1:0] sq;
      logic [18:0] rsum;
   } sqrt_tok_type;
endpackage
`default_nettype wire

FILE: src/scm_sqrt_cell.sv
// One cell of the square root chain: resolves one result bit per cycle
`default_nettype none
module scm_sqrt_cell (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic [scm_pkg::STEP_W-1:0] step,
   input  wire scm_pkg::sqrt_tok_type tok_in,
   output scm_pkg::sqrt_tok_type tok_out
);
   scm_pkg::sqrt_tok_type tok_ff, tok_in_c;
   logic [scm_pkg::SQ_W+1:0] trial;
   logic [scm_pkg::SQ_W+1:0] rem_sh;
   logic [scm_pkg::ROOT_W:0] root_sh;

   always_comb begin
      tok_in_c = tok_in;
      rem_sh = {2'b00, tok_in.rem};
      root_sh = tok_in.root << 1;
      trial = ({{(scm_pkg::SQ_W-scm_pkg::ROOT_W+1){1'b0}}, tok_in.root} << 2)
              | {{(scm_pkg::SQ_W+1){1'b0}}, 1'b1};
      rem_sh = (rem_sh << 2) | {{scm_pkg::SQ_W{1'b0}},
               tok_in.sq[2*step+1 +: 1], tok_in.sq[2*step +: 1]};
      if (rem_sh >= trial) begin
         tok_in_c.rem = scm_pkg::SQ_W'(rem_sh - trial);
         tok_in_c.root = root_sh | 1'b1;
      end else begin
         tok_in_c.rem = scm_pkg::SQ_W'(rem_sh);
         tok_in_c.root = root_sh;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff.valid <= tok_in.valid;
      end
      tok_ff.rem <= tok_in_c.rem;
      tok_ff.root <= tok_in_c.root;
      tok_ff.sq <= tok_in.sq;
      tok_ff.rsum <= tok_in.rsum;
   end

   assign tok_out = tok_ff;
endmodule
`default_nettype wire

FILE: src/sphere_clearance_min_core.sv
// Top level: obstacle table, distance front end, sqrt cell chain, minimum tracking
//
// A load is taken in one cycle and leaves busy low. A query streams the
// NUM_OBSTACLES table entries into a chain of 25 square root cells, one entry
// per cycle, then waits for the chain to drain: busy stays high through the
// FEED, DRAIN and DONE states, which span the table walk, the front end and
// the chain length. The result appears for one cycle on rsp_valid right after
// busy falls, and the receiver cannot stall it; the next transaction may be
// taken at that same edge.
`default_nettype none
`include "sphere_clearance_min_core_assert.svh"
module sphere_clearance_min_core (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   output logic busy,
   input  wire scm_pkg::req_type_type req_data,
   output logic rsp_valid,
   output scm_pkg::rsp_type rsp_data
);
   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001, ST_FEED = 4'b0010, ST_DRAIN = 4'b0100, ST_DONE = 4'b1000
   } state_type;

   scm_pkg::sphere_type tab [scm_pkg::NUM_OBSTACLES];
   scm_pkg::sphere_type rd_ff;
   state_type state_ff, state_in;
   scm_pkg::req_type_type q_ff;
   logic [scm_pkg::CNT_W-1:0] feed_ff, drain_ff;
   logic rdv_ff;
   logic signed [24:0] dx_ff, dy_ff, dz_ff;
   logic [18:0] rs_ff;
   logic dv_ff;
   logic [49:0] sx_ff, sy_ff, sz_ff;
   logic [18:0] rs2_ff;
   logic sv_ff;
   scm_pkg::sqrt_tok_type chain [scm_pkg::ROOT_W+1];
   logic signed [23:0] best_ff, run_ff, clr_ff;
   logic cv_ff;
   logic signed [27:0] diff;
   logic [scm_pkg::ROOT_W:0] rnd;
   logic rsp_valid_ff;
   scm_pkg::rsp_type rsp_in;

   always_ff @(posedge clock) begin
      if (start && !busy && req_data.req_type == scm_pkg::REQ_LOAD
          && 32'(req_data.entry_index) < scm_pkg::NUM_OBSTACLES) begin
         tab[scm_pkg::SLOT_W'(req_data.entry_index)] <= '{req_data.pos_x, req_data.pos_y,
                                                          req_data.pos_z, req_data.radius};
      end
      rd_ff <= tab[scm_pkg::SLOT_W'(feed_ff)];
   end

   assign busy = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (start && req_data.req_type == scm_pkg::REQ_QUERY) state_in = ST_FEED;
         ST_FEED: if (32'(feed_ff) == scm_pkg::NUM_OBSTACLES - 1) state_in = ST_DRAIN;
         ST_DRAIN: if (32'(drain_ff) == scm_pkg::ROOT_W + 6) state_in = ST_DONE;
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         feed_ff <= '0;
         drain_ff <= '0;
         rdv_ff <= 1'b0;
         dv_ff <= 1'b0;
         sv_ff <= 1'b0;
         cv_ff <= 1'b0;
         run_ff <= scm_pkg::CODE_MAX;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rdv_ff <= (state_ff == ST_FEED);
         dv_ff <= rdv_ff;
         sv_ff <= dv_ff;
         cv_ff <= chain[scm_pkg::ROOT_W].valid;
         rsp_valid_ff <= 1'b0;
         if (state_ff == ST_IDLE) begin
            feed_ff <= '0;
            drain_ff <= '0;
         end
         if (state_ff == ST_FEED) feed_ff <= feed_ff + 1'b1;
         if (state_ff == ST_DRAIN) drain_ff <= drain_ff + 1'b1;
         if (state_ff == ST_DONE) begin
            rsp_valid_ff <= 1'b1;
            if (q_ff.entry_index == 4'd0 || best_ff < run_ff) run_ff <= best_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) q_ff <= req_data;
      dx_ff <= 25'(q_ff.pos_x) - 25'(rd_ff.cx);
      dy_ff <= 25'(q_ff.pos_y) - 25'(rd_ff.cy);
      dz_ff <= 25'(q_ff.pos_z) - 25'(rd_ff.cz);
      rs_ff <= 19'(q_ff.radius) + 19'(rd_ff.rad);
      sx_ff <= $unsigned(50'(dx_ff) * 50'(dx_ff));
      sy_ff <= $unsigned(50'(dy_ff) * 50'(dy_ff));
      sz_ff <= $unsigned(50'(dz_ff) * 50'(dz_ff));
      rs2_ff <= rs_ff;
   end

   always_comb begin
      chain[0].valid = sv_ff;
      chain[0].rem = '0;
      chain[0].root = '0;
      chain[0].sq = sx_ff + sy_ff + sz_ff;
      chain[0].rsum = rs2_ff;
   end

   for (genvar g = 0; g < scm_pkg::ROOT_W; g++) begin : g_cell
      scm_sqrt_cell u_cell (
         .clock(clock), .reset(reset),
         .step(scm_pkg::STEP_W'(scm_pkg::ROOT_W - 1 - g)),
         .tok_in(chain[g]), .tok_out(chain[g+1])
      );
   end

   always_comb begin
      rnd = chain[scm_pkg::ROOT_W].root
            + ((chain[scm_pkg::ROOT_W].rem > {24'd0, chain[scm_pkg::ROOT_W].root}) ? 1'b1 : 1'b0);
      diff = 28'(rnd) - 28'(chain[scm_pkg::ROOT_W].rsum);
   end

   always_ff @(posedge clock) begin
      if (diff > 28'(scm_pkg::CODE_MAX)) clr_ff <= scm_pkg::CODE_MAX;
      else if (diff < 28'(scm_pkg::CODE_MIN)) clr_ff <= scm_pkg::CODE_MIN;
      else clr_ff <= 24'(diff);
      if (state_ff == ST_IDLE) best_ff <= scm_pkg::CODE_MAX;
      else if (cv_ff && clr_ff < best_ff) best_ff <= clr_ff;
   end

   always_comb begin
      rsp_in.point_clearance = best_ff;
      rsp_in.pose_clearance = (q_ff.entry_index == 4'd0 || best_ff < run_ff) ? best_ff : run_ff;
   end

   always_ff @(posedge clock) begin
      rsp_data <= rsp_in;
   end
   assign rsp_valid = rsp_valid_ff;

   `SCM_ASSERT_IMP(a_rsp_idle, clock, reset, rsp_valid, state_ff == ST_IDLE, "result outside idle")
   `SCM_ASSERT_NEXT(a_done_rsp, clock, reset, state_ff == ST_DONE, rsp_valid, "result missing")
   `SCM_ASSERT_IMP(a_feed_bound, clock, reset, state_ff == ST_FEED,
                   32'(feed_ff) < scm_pkg::NUM_OBSTACLES, "feed count overrun")
   `SCM_ASSERT_IMP(a_pose_le, clock, reset, rsp_valid,
                   rsp_data.pose_clearance <= rsp_data.point_clearance, "pose above point")
endmodule
`default_nettype wire
